@@ hdl/lfp_pkg.sv @@
// Shared constants and types for the lidar frame parser.
// No dependencies; imported by every module of the block.
package lfp_pkg;

  // Frame layout.
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned PosW       = $clog2(FrameBytes);
  localparam logic [7:0]  HdrByte    = 8'h59;

  // Frame byte positions with a fixed meaning.
  localparam logic [PosW-1:0] PosHdr0   = PosW'(0);
  localparam logic [PosW-1:0] PosHdr1   = PosW'(1);
  localparam logic [PosW-1:0] PosDistLo = PosW'(2);
  localparam logic [PosW-1:0] PosDistHi = PosW'(3);
  localparam logic [PosW:0]   PosLimit  = (PosW + 1)'(FrameBytes);
  localparam logic [PosW:0]   PosCsum   = (PosW + 1)'(FrameBytes - 1);

  // Near threshold after reset.
  localparam logic [15:0] ThreshReset = 16'd5;

  // Queue between the parser and the trend stage.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One request from the parser: a good frame's distance.
  typedef struct packed {
    logic        valid;
    logic [15:0] distance;
  } lfp_frame_t;

endpackage

@@ hdl/lfp_front.sv @@
// Front part: hunts for frame headers, sums bytes and checks the checksum.
// Depends on lfp_pkg; emits one request per good frame.
module lfp_front
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  output lfp_frame_t  frame_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      dist_lo_q, dist_lo_d;
  logic [7:0]      dist_hi_q, dist_hi_d;
  logic [PosW:0]   pos_ext;
  logic [7:0]      sum_next;

  assign pos_ext  = {1'b0, pos_q};
  assign sum_next = sum_q + rx_byte_i;

  // Byte classification and next parser state.
  always_comb begin
    pos_d             = pos_q;
    sum_d             = sum_q;
    dist_lo_d         = dist_lo_q;
    dist_hi_d         = dist_hi_q;
    frame_o.valid     = 1'b0;
    frame_o.distance  = {dist_hi_q, dist_lo_q};
    if (accept_i) begin
      if (pos_ext >= PosLimit || pos_q == PosHdr0) begin
        // Hunting for the first header byte.
        if (rx_byte_i == HdrByte) begin
          sum_d = rx_byte_i;
          pos_d = PosHdr1;
        end else begin
          sum_d = 8'd0;
          pos_d = PosHdr0;
        end
      end else if (pos_q == PosHdr1) begin
        // A bad second header byte is not retried as a first header.
        if (rx_byte_i == HdrByte) begin
          sum_d = sum_next;
          pos_d = pos_q + PosW'(1);
        end else begin
          sum_d = 8'd0;
          pos_d = PosHdr0;
        end
      end else if (pos_ext < PosCsum) begin
        // Payload bytes.
        if (pos_q == PosDistLo) begin
          dist_lo_d = rx_byte_i;
        end else if (pos_q == PosDistHi) begin
          dist_hi_d = rx_byte_i;
        end
        sum_d = sum_next;
        pos_d = pos_q + PosW'(1);
      end else begin
        // Checksum byte ends the frame either way.
        frame_o.valid = (rx_byte_i == sum_q);
        sum_d         = 8'd0;
        pos_d         = PosHdr0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosHdr0;
      sum_q     <= 8'd0;
      dist_lo_q <= 8'd0;
      dist_hi_q <= 8'd0;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      dist_lo_q <= dist_lo_d;
      dist_hi_q <= dist_hi_d;
    end
  end

endmodule

@@ hdl/lfp_fifo.sv @@
// Short queue of good-frame distances between the parser and the trend stage.
// Depends on lfp_pkg for depth and request type.
module lfp_fifo
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lfp_frame_t  wr_i,
  output logic        full_o,
  input  logic        rd_i,
  output lfp_frame_t  rd_o
);

  logic [15:0]      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_wr, do_rd;

  assign full_o      = (count_q == (QPtrW + 1)'(QDepth));
  assign rd_o.valid  = (count_q != '0);
  assign rd_o.distance = mem_q[rd_ptr_q];
  assign do_wr       = wr_i.valid;
  assign do_rd       = rd_i && rd_o.valid;

  // Storage; written only when the parser is allowed to take bytes.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.distance;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (QPtrW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (QPtrW + 1)'(1);
      end
    end
  end

endmodule

@@ hdl/lfp_back.sv @@
// Back part: updates the trend flags and holds the result register.
// Depends on lfp_pkg; takes requests from lfp_fifo.
module lfp_back
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] threshold_i,
  input  lfp_frame_t  frame_i,
  output logic        take_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] distance_o,
  output logic        moving_closer_o,
  output logic        moving_further_o
);

  logic        out_valid_q;
  logic [15:0] dist_q;
  logic [15:0] last_q;
  logic        closer_q, closer_d;
  logic        further_q, further_d;

  assign empty_o          = !out_valid_q;
  assign distance_o       = dist_q;
  assign moving_closer_o  = closer_q;
  assign moving_further_o = further_q;

  // A new request moves in when the result register is free or being taken.
  assign take_o = frame_i.valid && (!out_valid_q || pop_i);

  // Trend update against the previous good distance; both flags clear at or below the threshold.
  always_comb begin
    closer_d  = closer_q;
    further_d = further_q;
    if (frame_i.distance > threshold_i) begin
      if (frame_i.distance > last_q) begin
        closer_d  = 1'b0;
        further_d = 1'b1;
      end else if (frame_i.distance < last_q) begin
        closer_d  = 1'b1;
        further_d = 1'b0;
      end
    end else begin
      closer_d  = 1'b0;
      further_d = 1'b0;
    end
  end

  // Result register and trend state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dist_q      <= 16'd0;
      last_q      <= 16'd0;
      closer_q    <= 1'b0;
      further_q   <= 1'b0;
    end else begin
      if (take_o) begin
        out_valid_q <= 1'b1;
        dist_q      <= frame_i.distance;
        last_q      <= frame_i.distance;
        closer_q    <= closer_d;
        further_q   <= further_d;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/lidar_frame_parser_with_trend.sv @@
// Top level of the lidar frame parser with distance trend flags.
// Depends on lfp_pkg, lfp_front, lfp_fifo and lfp_back.
//
//   Channel   Handshake          Payload
//   input     push / full        rx_byte_i
//   result    empty / pop        distance_o, moving_closer_o, moving_further_o
//   config    cfg_we_i           cfg_data_i (near threshold)
//
// One byte is taken every cycle while push is high and full is low. A good
// frame's result passes, after its checksum byte, through the distance queue
// and then the result register. full rises only when the two-entry distance
// queue is full, which happens when results are not popped. Reset is
// asynchronous and needs no clearing pass; the threshold resets to 5.
module lidar_frame_parser_with_trend
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] distance_o,
  output logic        moving_closer_o,
  output logic        moving_further_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] threshold_q;
  logic        accept;
  logic        take;
  lfp_frame_t  front_req;
  lfp_frame_t  queue_req;

  // Input request is accepted when the queue has room.
  assign accept = push && !full;

  // Near threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThreshReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  lfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .frame_o   (front_req)
  );

  lfp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (front_req),
    .full_o (full),
    .rd_i   (take),
    .rd_o   (queue_req)
  );

  lfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .threshold_i      (threshold_q),
    .frame_i          (queue_req),
    .take_o           (take),
    .empty_o          (empty),
    .pop_i            (pop),
    .distance_o       (distance_o),
    .moving_closer_o  (moving_closer_o),
    .moving_further_o (moving_further_o)
  );

endmodule
